### hdl/ctt_pkg.sv
`timescale 1ns / 1ps
// ctt_pkg: shared types and constants of the config text tokenizer.
// Character codes, token kinds, result item type and keyword spelling.
// No dependencies.
package ctt_pkg;

  localparam int FIELD_W   = 24;
  localparam int KIND_W    = 5;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_LVL_W   = $clog2(Q_DEPTH + 1);

  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [KIND_W-1:0]  kind_t;

  localparam kind_t K_SPACE   = 5'd0;
  localparam kind_t K_COMMENT = 5'd1;
  localparam kind_t K_NEWLINE = 5'd2;
  localparam kind_t K_STRING  = 5'd3;
  localparam kind_t K_INT     = 5'd4;
  localparam kind_t K_FLOAT   = 5'd5;
  localparam kind_t K_SCI     = 5'd6;
  localparam kind_t K_BOOL    = 5'd7;
  localparam kind_t K_LBRACE  = 5'd8;
  localparam kind_t K_RBRACE  = 5'd9;
  localparam kind_t K_COLON   = 5'd10;
  localparam kind_t K_LBRACK  = 5'd11;
  localparam kind_t K_RBRACK  = 5'd12;
  localparam kind_t K_COMMA   = 5'd13;
  localparam kind_t K_STAR    = 5'd14;
  localparam kind_t K_PLUS    = 5'd15;
  localparam kind_t K_MINUS   = 5'd16;
  localparam kind_t K_SLASH   = 5'd17;
  localparam kind_t K_EOF     = 5'd18;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_UP_T   = 8'h54;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LO_E   = 8'h65;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_LO_T   = 8'h74;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CASE_BIT  = 8'h20;

  typedef struct packed {
    kind_t  kind;
    field_t first_pos;
    field_t last_pos;
    field_t line;
    logic   err;
    logic   run_last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  // lowercase letter n of "true" or "false"
  function automatic logic [7:0] kw_char(input logic is_true, input logic [2:0] n);
    logic [7:0] ch;
    ch = 8'h00;
    if (is_true) begin
      case (n)
        3'd0: ch = 8'h74;
        3'd1: ch = 8'h72;
        3'd2: ch = 8'h75;
        3'd3: ch = 8'h65;
        default: ch = 8'h00;
      endcase
    end else begin
      case (n)
        3'd0: ch = 8'h66;
        3'd1: ch = 8'h61;
        3'd2: ch = 8'h6C;
        3'd3: ch = 8'h73;
        3'd4: ch = 8'h65;
        default: ch = 8'h00;
      endcase
    end
    return ch;
  endfunction

endpackage

### hdl/ctt_lexer.sv
`timescale 1ns / 1ps
// ctt_lexer: lexer state and the per-byte step that yields up to two results.
// Depends on ctt_pkg.
module ctt_lexer #(
  parameter int POSITION_BITS = 24
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic [7:0]     text_byte,
  input  logic           end_of_text,
  output ctt_pkg::push_t push
);

  typedef enum logic [2:0] {
    MODE_DEFAULT,
    MODE_SPACE,
    MODE_COMMENT,
    MODE_NUMBER,
    MODE_STRING,
    MODE_KEYWORD
  } mode_t;

  typedef logic [POSITION_BITS-1:0] pos_t;

  localparam pos_t POS_MAX = {POSITION_BITS{1'b1}};
  localparam pos_t POS_ONE = pos_t'(1);

  mode_t          mode, mode_next;
  ctt_pkg::kind_t open_kind, open_kind_next;
  pos_t           open_start, open_start_next;
  pos_t           open_line, open_line_next;
  pos_t           byte_position, byte_position_next;
  pos_t           line_count, line_count_next;
  pos_t           prev_position, prev_position_next;
  logic [3:0]     kw_progress, kw_progress_next;
  logic           error_seen, error_seen_next;

  ctt_pkg::res_t  res_a, res_b;
  logic           a_vld, b_vld;
  logic           do_def;
  logic           is_true;
  logic [2:0]     kw_n;
  logic [2:0]     kw_len;
  pos_t           p;
  pos_t           line_inc;
  logic           is_digit;

  function automatic ctt_pkg::res_t mk(input ctt_pkg::kind_t k, input pos_t f,
                                       input pos_t l, input pos_t ln);
    ctt_pkg::res_t r;
    r.kind      = k;
    r.first_pos = ctt_pkg::field_t'(f);
    r.last_pos  = ctt_pkg::field_t'(l);
    r.line      = ctt_pkg::field_t'(ln);
    r.err       = 1'b0;
    r.run_last  = 1'b0;
    return r;
  endfunction

  function automatic ctt_pkg::res_t mk_err();
    ctt_pkg::res_t r;
    r     = '0;
    r.err = 1'b1;
    return r;
  endfunction

  always_comb begin
    mode_next          = mode;
    open_kind_next     = open_kind;
    open_start_next    = open_start;
    open_line_next     = open_line;
    byte_position_next = byte_position;
    line_count_next    = line_count;
    prev_position_next = prev_position;
    kw_progress_next   = kw_progress;
    error_seen_next    = error_seen;
    res_a  = '0;
    res_b  = '0;
    a_vld  = 1'b0;
    b_vld  = 1'b0;
    do_def = 1'b0;
    p        = byte_position;
    line_inc = (line_count == POS_MAX) ? line_count : line_count + POS_ONE;
    is_digit = (text_byte >= ctt_pkg::CH_ZERO) && (text_byte <= ctt_pkg::CH_NINE);
    is_true  = kw_progress[3];
    kw_n     = kw_progress[2:0];
    kw_len   = is_true ? 3'd4 : 3'd5;

    if (end_of_text) begin
      if (!error_seen) begin
        if (mode == MODE_KEYWORD) begin
          res_a = mk_err();
          a_vld = 1'b1;
        end else if (mode != MODE_DEFAULT) begin
          res_a = mk(open_kind, open_start, prev_position, open_line);
          a_vld = 1'b1;
        end
      end
      res_b = mk(ctt_pkg::K_EOF, p, p, line_count);
      b_vld = 1'b1;
      mode_next          = MODE_DEFAULT;
      open_kind_next     = '0;
      open_start_next    = '0;
      open_line_next     = '0;
      byte_position_next = '0;
      line_count_next    = POS_ONE;
      prev_position_next = '0;
      kw_progress_next   = '0;
      error_seen_next    = 1'b0;
    end else if (!error_seen) begin
      case (mode)
        MODE_SPACE: begin
          if (text_byte != ctt_pkg::CH_SPACE) begin
            res_a = mk(open_kind, open_start, prev_position, open_line);
            a_vld = 1'b1;
            mode_next = MODE_DEFAULT;
            do_def = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (text_byte == ctt_pkg::CH_NL) begin
            res_a = mk(open_kind, open_start, prev_position, open_line);
            a_vld = 1'b1;
            mode_next = MODE_DEFAULT;
            do_def = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (is_digit) begin
            mode_next = MODE_NUMBER;
          end else if (text_byte == ctt_pkg::CH_DOT) begin
            open_kind_next = ctt_pkg::K_FLOAT;
          end else if (text_byte == ctt_pkg::CH_LO_E) begin
            open_kind_next = ctt_pkg::K_SCI;
          end else if ((text_byte == ctt_pkg::CH_PLUS || text_byte == ctt_pkg::CH_MINUS)
                       && open_kind == ctt_pkg::K_SCI) begin
            mode_next = MODE_NUMBER;
          end else begin
            res_a = mk(open_kind, open_start, prev_position, open_line);
            a_vld = 1'b1;
            mode_next = MODE_DEFAULT;
            do_def = 1'b1;
          end
        end
        MODE_STRING: begin
          if (text_byte == ctt_pkg::CH_QUOTE) begin
            res_b = mk(ctt_pkg::K_STRING, open_start, p, open_line);
            b_vld = 1'b1;
            mode_next = MODE_DEFAULT;
          end
        end
        MODE_KEYWORD: begin
          if (kw_n >= kw_len ||
              (text_byte | ctt_pkg::CASE_BIT) != ctt_pkg::kw_char(is_true, kw_n)) begin
            res_b = mk_err();
            b_vld = 1'b1;
            error_seen_next  = 1'b1;
            mode_next        = MODE_DEFAULT;
            kw_progress_next = '0;
          end else if (kw_n + 3'd1 == kw_len) begin
            res_b = mk(ctt_pkg::K_BOOL, open_start, p, open_line);
            b_vld = 1'b1;
            mode_next        = MODE_DEFAULT;
            kw_progress_next = '0;
          end else begin
            kw_progress_next = {is_true, kw_n + 3'd1};
          end
        end
        default: begin
          mode_next = MODE_DEFAULT;
          do_def = 1'b1;
        end
      endcase

      if (do_def) begin
        case (text_byte)
          ctt_pkg::CH_SPACE, ctt_pkg::CH_TAB: begin
            mode_next = MODE_SPACE;
            open_kind_next = ctt_pkg::K_SPACE;
            open_start_next = p;
            open_line_next = line_count;
          end
          ctt_pkg::CH_HASH: begin
            mode_next = MODE_COMMENT;
            open_kind_next = ctt_pkg::K_COMMENT;
            open_start_next = p;
            open_line_next = line_count;
          end
          ctt_pkg::CH_QUOTE: begin
            mode_next = MODE_STRING;
            open_kind_next = ctt_pkg::K_STRING;
            open_start_next = p;
            open_line_next = line_count;
          end
          ctt_pkg::CH_NL: begin
            line_count_next = line_inc;
            res_b = mk(ctt_pkg::K_NEWLINE, p, p, line_inc);
            b_vld = 1'b1;
          end
          ctt_pkg::CH_LO_F, ctt_pkg::CH_UP_F: begin
            mode_next = MODE_KEYWORD;
            open_kind_next = ctt_pkg::K_BOOL;
            open_start_next = p;
            open_line_next = line_count;
            kw_progress_next = 4'b0001;
          end
          ctt_pkg::CH_LO_T, ctt_pkg::CH_UP_T: begin
            mode_next = MODE_KEYWORD;
            open_kind_next = ctt_pkg::K_BOOL;
            open_start_next = p;
            open_line_next = line_count;
            kw_progress_next = 4'b1001;
          end
          ctt_pkg::CH_LBRACE: begin
            res_b = mk(ctt_pkg::K_LBRACE, p, p, line_count);
            b_vld = 1'b1;
          end
          ctt_pkg::CH_RBRACE: begin
            res_b = mk(ctt_pkg::K_RBRACE, p, p, line_count);
            b_vld = 1'b1;
          end
          ctt_pkg::CH_COLON: begin
            res_b = mk(ctt_pkg::K_COLON, p, p, line_count);
            b_vld = 1'b1;
          end
          ctt_pkg::CH_LBRACK: begin
            res_b = mk(ctt_pkg::K_LBRACK, p, p, line_count);
            b_vld = 1'b1;
          end
          ctt_pkg::CH_RBRACK: begin
            res_b = mk(ctt_pkg::K_RBRACK, p, p, line_count);
            b_vld = 1'b1;
          end
          ctt_pkg::CH_COMMA: begin
            res_b = mk(ctt_pkg::K_COMMA, p, p, line_count);
            b_vld = 1'b1;
          end
          ctt_pkg::CH_STAR: begin
            res_b = mk(ctt_pkg::K_STAR, p, p, line_count);
            b_vld = 1'b1;
          end
          ctt_pkg::CH_PLUS: begin
            res_b = mk(ctt_pkg::K_PLUS, p, p, line_count);
            b_vld = 1'b1;
          end
          ctt_pkg::CH_MINUS: begin
            res_b = mk(ctt_pkg::K_MINUS, p, p, line_count);
            b_vld = 1'b1;
          end
          ctt_pkg::CH_SLASH: begin
            res_b = mk(ctt_pkg::K_SLASH, p, p, line_count);
            b_vld = 1'b1;
          end
          default: begin
            if (is_digit) begin
              mode_next = MODE_NUMBER;
              open_kind_next = ctt_pkg::K_INT;
              open_start_next = p;
              open_line_next = line_count;
            end else begin
              res_b = mk_err();
              b_vld = 1'b1;
              error_seen_next  = 1'b1;
              mode_next        = MODE_DEFAULT;
              kw_progress_next = '0;
            end
          end
        endcase
      end

      prev_position_next = p;
      byte_position_next = (byte_position == POS_MAX) ? byte_position
                                                      : byte_position + POS_ONE;
    end
  end

  // pack results in order: closed token first, then the new one
  always_comb begin
    push    = '0;
    push.n  = {1'b0, a_vld} + {1'b0, b_vld};
    if (!step) begin
      push.n = 2'd0;
    end
    if (a_vld) begin
      push.r0 = res_a;
      push.r0.run_last = !b_vld;
      push.r1 = res_b;
      push.r1.run_last = 1'b1;
    end else begin
      push.r0 = res_b;
      push.r0.run_last = 1'b1;
      push.r1 = res_b;
      push.r1.run_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_DEFAULT;
      open_kind     <= '0;
      open_start    <= '0;
      open_line     <= '0;
      byte_position <= '0;
      line_count    <= POS_ONE;
      prev_position <= '0;
      kw_progress   <= '0;
      error_seen    <= 1'b0;
    end else if (step) begin
      mode          <= mode_next;
      open_kind     <= open_kind_next;
      open_start    <= open_start_next;
      open_line     <= open_line_next;
      byte_position <= byte_position_next;
      line_count    <= line_count_next;
      prev_position <= prev_position_next;
      kw_progress   <= kw_progress_next;
      error_seen    <= error_seen_next;
    end
  end

endmodule

### hdl/ctt_queue.sv
`timescale 1ns / 1ps
// ctt_queue: result queue, takes up to two items a cycle, gives one.
// Depends on ctt_pkg.
module ctt_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  ctt_pkg::push_t                push,
  input  logic                          pop,
  output logic                          nonempty,
  output logic [ctt_pkg::Q_LVL_W-1:0]   level,
  output ctt_pkg::res_t                 head
);

  ctt_pkg::res_t                 slots [ctt_pkg::Q_DEPTH];
  logic [ctt_pkg::Q_PTR_W-1:0]   rd_ptr;
  logic [ctt_pkg::Q_PTR_W-1:0]   wr_ptr;
  logic                          do_pop;

  assign nonempty = (level != '0);
  assign do_pop   = pop && nonempty;
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      slots[wr_ptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      slots[wr_ptr + ctt_pkg::Q_PTR_W'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + ctt_pkg::Q_PTR_W'(push.n);
      rd_ptr <= rd_ptr + ctt_pkg::Q_PTR_W'(do_pop);
      level  <= level + ctt_pkg::Q_LVL_W'(push.n) - ctt_pkg::Q_LVL_W'(do_pop);
    end
  end

endmodule

### hdl/config_text_tokenizer.sv
`timescale 1ns / 1ps
// config_text_tokenizer: streaming lexer, one text byte per item in, tokens out.
// An accepted item is held in a register, then lexed into the result queue.
// Throughput: one item per cycle; each item yields 0 to 2 tokens, and the
// four-entry result queue stalls input when fewer than two slots are free.
// Reset (rst, synchronous): lexer in default mode, position 0, line 1, queue empty.
module config_text_tokenizer #(
  parameter int POSITION_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        text_valid,
  output logic                        text_stall,
  input  logic [7:0]                  text_byte,
  input  logic                        end_of_text,
  output logic                        token_valid,
  input  logic                        token_stall,
  output logic [ctt_pkg::KIND_W-1:0]  token_kind,
  output logic [ctt_pkg::FIELD_W-1:0] first_position,
  output logic [ctt_pkg::FIELD_W-1:0] last_position,
  output logic [ctt_pkg::FIELD_W-1:0] line_number,
  output logic                        lex_error,
  output logic                        last_of_run
);

  logic                         hold_valid;
  logic [7:0]                   hold_byte;
  logic                         hold_end;
  logic                         room;
  logic                         step;
  logic [ctt_pkg::Q_LVL_W-1:0]  level;
  ctt_pkg::push_t               push;
  ctt_pkg::res_t                head;

  assign room       = (level <= ctt_pkg::Q_LVL_W'(ctt_pkg::Q_DEPTH - 2));
  assign step       = hold_valid && room;
  assign text_stall = hold_valid && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!text_stall) begin
      hold_valid <= text_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!text_stall) begin
      hold_byte <= text_byte;
      hold_end  <= end_of_text;
    end
  end

  ctt_lexer #(
    .POSITION_BITS(POSITION_BITS)
  ) u_lexer (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .text_byte   (hold_byte),
    .end_of_text (hold_end),
    .push        (push)
  );

  ctt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .pop      (!token_stall),
    .nonempty (token_valid),
    .level    (level),
    .head     (head)
  );

  assign token_kind     = head.kind;
  assign first_position = head.first_pos;
  assign last_position  = head.last_pos;
  assign line_number    = head.line;
  assign lex_error      = head.err;
  assign last_of_run    = head.run_last;

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= ctt_pkg::Q_LVL_W'(ctt_pkg::Q_DEPTH))
    else $error("result queue overflow");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (token_valid && lex_error) |->
      (token_kind == '0 && first_position == '0 && last_position == '0 &&
       line_number == '0))
    else $error("error item carries token fields");

  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    (token_valid && !lex_error && token_kind == ctt_pkg::K_EOF) |-> last_of_run)
    else $error("eof item is not last of its run");

  a_reset_ready: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !text_stall)
    else $error("input stalled right after reset");

endmodule
